// ===== rtl/mlft_pkg.sv =====
// Package: shared types and constants for the MAC learning forwarding table.
`default_nettype none
package mlft_pkg;

	localparam int AddrWidth = 48;
	localparam int PortWidth = 2;
	localparam int MaskWidth = 4;

	localparam logic [AddrWidth-1:0] BcastAddr = {AddrWidth{1'b1}};

	typedef logic [AddrWidth-1:0] mac_addr_t;
	typedef logic [PortWidth-1:0] port_t;
	typedef logic [MaskWidth-1:0] port_mask_t;

	// Header request
	typedef struct packed {
		mac_addr_t source_address;
		mac_addr_t destination_address;
		port_t     ingress_port;
	} req_t;

	// Forwarding decision
	typedef struct packed {
		port_mask_t forward_mask;
		logic       destination_known;
		logic       broadcast_seen;
	} rsp_t;

	// One learned table word
	typedef struct packed {
		port_t     port;
		mac_addr_t address;
	} entry_t;

	// Scan results handed from the compare unit to the sequencer
	typedef struct packed {
		logic  src_hit;
		logic  dst_hit;
		port_t dst_port;
	} match_t;

endpackage
`default_nettype wire

// ===== rtl/mlft_stream_if.sv =====
// Interface: valid/ready channel carrying one payload per request.
`default_nettype none
interface mlft_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/mlft_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module mlft_ram #(
	parameter int Width = 8,
	parameter int Depth = 16,
	localparam int AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [AddrWidth-1:0] waddr,
	input  wire logic [Width-1:0]     wdata,
	input  wire logic [AddrWidth-1:0] raddr,
	output logic      [Width-1:0]     rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/mlft_match.sv =====
// Compare unit: checks one table word per cycle against both keys, keeps hits.
`default_nettype none
module mlft_match #(
	parameter int IdxWidth = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                clear,
	input  wire logic                cmp_vld,
	input  wire logic [IdxWidth-1:0] cmp_idx,
	input  wire mlft_pkg::entry_t    entry,
	input  wire mlft_pkg::mac_addr_t src_key,
	input  wire mlft_pkg::mac_addr_t dst_key,
	output mlft_pkg::match_t         hits,
	output logic      [IdxWidth-1:0] src_idx,
	output logic      [IdxWidth-1:0] dst_idx
);
	import mlft_pkg::*;

	logic  src_eq;
	logic  dst_eq;
	logic  src_hit_q;
	logic  dst_hit_q;
	port_t dst_port_q;

	assign src_eq = (entry.address == src_key);
	assign dst_eq = (entry.address == dst_key);

	assign hits = '{src_hit: src_hit_q, dst_hit: dst_hit_q, dst_port: dst_port_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_hit_q <= 1'b0;
			dst_hit_q <= 1'b0;
		end else if (clear) begin
			src_hit_q <= 1'b0;
			dst_hit_q <= 1'b0;
		end else if (cmp_vld) begin
			if (src_eq) src_hit_q <= 1'b1;
			if (dst_eq) dst_hit_q <= 1'b1;
		end
	end

	// Addresses in the table are unique, so at most one word hits each key.
	always_ff @(posedge clk) begin
		if (cmp_vld && src_eq) begin
			src_idx <= cmp_idx;
		end
		if (cmp_vld && dst_eq) begin
			dst_idx    <= cmp_idx;
			dst_port_q <= entry.port;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/mac_learning_forwarding_table_unit.sv =====
// Top level: MAC learning and forwarding table with a sequential table scan.
`default_nettype none
// Usage
//  req (sink): one frame header per request - source MAC, destination MAC,
//    ingress port. rsp (source): one forwarding decision per request -
//    port mask, destination-known flag, broadcast flag.
//  Learned entries always sit packed at the low end of the table, so a fill
//    count stands in for per-entry valid bits and reset needs no clearing pass.
//  Each header scans the n learned entries (n <= TABLE_ENTRIES) through one
//    table RAM read port, one entry per cycle, while a compare stage checks
//    each word against source and destination together. Then the learn
//    state learns the source (port update, free entry, or round-robin victim)
//    and loads the decision into the output register.
//  Steps: scan reads, a flush for the last compare, learn, then rsp.valid
//    from the output register (an empty table goes straight to learn).
//  A header is taken only in idle. A waiting decision does not block the
//    next request: the block returns to idle and takes the next header;
//    that header's decision is held back until rsp drains.
//  Reset (arst_n low, asynchronous): table empty, victim pointer zero,
//    no decision pending.
module mac_learning_forwarding_table_unit #(
	parameter int TABLE_ENTRIES = 16,
	parameter int PORT_COUNT    = 4
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	mlft_stream_if.sink   req,
	mlft_stream_if.source rsp
);
	import mlft_pkg::*;

	localparam int IdxWidth = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CntWidth = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CntWidth-1:0] FullCount = CntWidth'(TABLE_ENTRIES);
	localparam logic [IdxWidth-1:0] LastIdx   = IdxWidth'(TABLE_ENTRIES - 1);
	localparam port_mask_t PortMask =
		(PORT_COUNT >= MaskWidth) ? {MaskWidth{1'b1}} : MaskWidth'((1 << PORT_COUNT) - 1);

	// sequencer codes
	localparam logic [1:0] StIdle  = 2'd0;
	localparam logic [1:0] StScan  = 2'd1; // issue reads
	localparam logic [1:0] StFlush = 2'd2; // last compare
	localparam logic [1:0] StLearn = 2'd3; // write table, load decision

	logic [1:0]          state_q;
	req_t                req_q;
	logic [CntWidth-1:0] fill_q;     // learned entries, always 0..fill_q-1
	logic [IdxWidth-1:0] victim_q;
	logic [IdxWidth-1:0] idx_q;      // scan read address
	logic                cmp_vld_s1;
	logic [IdxWidth-1:0] cmp_idx_s1;
	logic                rsp_vld_q;
	rsp_t                rsp_q;

	entry_t              rd_entry;
	entry_t              wr_entry;
	match_t              hits;
	logic [IdxWidth-1:0] src_idx;
	logic [IdxWidth-1:0] dst_idx;

	logic                req_fire;
	logic                last_rd;
	logic                learn_go;
	logic                full;
	logic                evict;
	logic [IdxWidth-1:0] wr_idx;
	logic                bcast;
	logic                self_dst;
	logic                known;
	port_t               fwd_port;
	port_mask_t          mask;

	assign req.ready = (state_q == StIdle);
	assign req_fire  = req.valid && req.ready;
	assign rsp.valid   = rsp_vld_q;
	assign rsp.payload = rsp_q;

	assign last_rd  = (CntWidth'(idx_q) + CntWidth'(1)) == fill_q;
	assign learn_go = (state_q == StLearn) && (!rsp_vld_q || rsp.ready);

	// --- learn decision ---
	assign full  = (fill_q == FullCount);
	assign evict = !hits.src_hit && full;
	always_comb begin
		if (hits.src_hit) begin
			wr_idx = src_idx;
		end else if (full) begin
			wr_idx = victim_q;
		end else begin
			wr_idx = fill_q[IdxWidth-1:0];
		end
	end
	assign wr_entry.port    = req_q.ingress_port;
	assign wr_entry.address = req_q.source_address;

	// --- forward decision, as seen after learning ---
	// A destination equal to the source is found at its fresh entry; a
	// destination found in the scan is lost if learning evicts its entry.
	assign bcast    = (req_q.destination_address == BcastAddr);
	assign self_dst = (req_q.destination_address == req_q.source_address);
	assign known    = !bcast && (self_dst ||
		(hits.dst_hit && !(evict && (victim_q == dst_idx))));
	assign fwd_port = self_dst ? req_q.ingress_port : hits.dst_port;
	assign mask     = known ? (PortMask & (MaskWidth'(1) << fwd_port))
		: (PortMask & ~(MaskWidth'(1) << req_q.ingress_port));

	// --- sequencer ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= StIdle;
			fill_q     <= '0;
			victim_q   <= '0;
			idx_q      <= '0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			cmp_vld_s1 <= (state_q == StScan);
			unique case (state_q)
				StIdle: begin
					if (req_fire) begin
						idx_q   <= '0;
						state_q <= (fill_q == '0) ? StLearn : StScan;
					end
				end
				StScan: begin
					idx_q <= idx_q + IdxWidth'(1);
					if (last_rd) state_q <= StFlush;
				end
				StFlush: begin
					state_q <= StLearn;
				end
				StLearn: begin
					if (learn_go) begin
						state_q <= StIdle;
						if (!hits.src_hit) begin
							if (full) begin
								victim_q <= (victim_q == LastIdx) ? '0 : victim_q + IdxWidth'(1);
							end else begin
								fill_q <= fill_q + CntWidth'(1);
							end
						end
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= idx_q;
		if (req_fire) req_q <= req.payload;
		if (learn_go) begin
			rsp_q.forward_mask      <= mask;
			rsp_q.destination_known <= known;
			rsp_q.broadcast_seen    <= bcast;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (learn_go) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	mlft_ram #(
		.Width($bits(entry_t)),
		.Depth(TABLE_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (learn_go),
		.waddr(wr_idx),
		.wdata(wr_entry),
		.raddr(idx_q),
		.rdata(rd_entry)
	);

	mlft_match #(
		.IdxWidth(IdxWidth)
	) u_match (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (req_fire),
		.cmp_vld(cmp_vld_s1),
		.cmp_idx(cmp_idx_s1),
		.entry  (rd_entry),
		.src_key(req_q.source_address),
		.dst_key(req_q.destination_address),
		.hits   (hits),
		.src_idx(src_idx),
		.dst_idx(dst_idx)
	);

`ifndef SYNTH
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FullCount)
		else $error("fill count beyond table size");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == StScan) |-> (CntWidth'(idx_q) < fill_q))
		else $error("scan reads an unlearned entry");

	a_victim_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(victim_q) |-> $past(fill_q == FullCount))
		else $error("victim pointer moved with free entries left");

	a_learn_loads_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		learn_go |=> rsp_vld_q && (state_q == StIdle))
		else $error("decision not loaded after learn");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> (state_q == StScan) || (state_q == StLearn))
		else $error("accepted request did not start a lookup");
`endif
endmodule
`default_nettype wire
